// ===== rtl/hqt_pkg.sv =====
// Shared types and constants for the heat quartile threshold block.
package hqt_pkg;

   localparam int HEAT_W  = 64;
   localparam int COUNT_W = 11;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_OUTER,
      ST_KEY,
      ST_CMP,
      ST_PLACE,
      ST_RD_LOW,
      ST_RD_MID,
      ST_RD_HIGH,
      ST_CAP_HIGH,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctrl_type;

endpackage

// ===== rtl/hqt_store.sv =====
// Heat value store: one write port, one read port with registered read data.
module hqt_store import hqt_pkg::*; #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                clock,
   input  mem_ctrl_type        ctrl,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [HEAT_W-1:0]   wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [HEAT_W-1:0]   rd_data_ff
);

   logic [HEAT_W-1:0] heat_mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         heat_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= heat_mem_ff[rd_addr];
      end
   end

endmodule

// ===== rtl/hqt_seq.sv =====
// Sequencer: loads words, insertion-sorts the store with one comparator, picks quartiles.
module hqt_seq import hqt_pkg::*; #(
   parameter int MAX_ENTRIES = 1024,
   parameter int ADDR_W      = 10,
   parameter int CNT_W       = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [HEAT_W-1:0]   req_heat,
   input  logic                req_carries_heat,
   input  logic                req_is_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [HEAT_W-1:0]   rsp_quartile_low,
   output logic [HEAT_W-1:0]   rsp_quartile_mid,
   output logic [HEAT_W-1:0]   rsp_quartile_high,
   output logic [COUNT_W-1:0]  rsp_entries_used,
   output mem_ctrl_type        mem_ctrl,
   output logic [ADDR_W-1:0]   mem_wr_addr,
   output logic [HEAT_W-1:0]   mem_wr_data,
   output logic [ADDR_W-1:0]   mem_rd_addr,
   input  logic [HEAT_W-1:0]   mem_rd_data
);

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          i_ff, i_in;
   logic [ADDR_W-1:0]         j_ff, j_in;
   logic signed [HEAT_W-1:0]  key_ff, key_in;
   logic [HEAT_W-1:0]         q_low_ff, q_low_in;
   logic [HEAT_W-1:0]         q_mid_ff, q_mid_in;
   logic [HEAT_W-1:0]         q_high_ff, q_high_in;

   logic                      accept;
   logic                      room;
   logic                      key_less;
   logic [CNT_W-1:0]          pos_low;
   logic [CNT_W-1:0]          pos_mid;
   logic [CNT_W+1:0]          three_n;
   logic [CNT_W-1:0]          pos_high;

   assign accept   = req_valid && !req_stall;
   assign room     = count_ff < CNT_W'(MAX_ENTRIES);
   assign key_less = key_ff < $signed(mem_rd_data);

   // n*25/100 = n/4, n*50/100 = n/2, n*75/100 = 3n/4, all floored
   assign pos_low  = count_ff >> 2;
   assign pos_mid  = count_ff >> 1;
   assign three_n  = {2'b00, count_ff} + {1'b0, count_ff, 1'b0};
   assign pos_high = three_n[CNT_W+1:2];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept && req_is_last) begin
               state_in = ST_OUTER;
            end
         end
         ST_OUTER: begin
            if (i_ff >= count_ff) begin
               state_in = (count_ff == '0) ? ST_RESULT : ST_RD_LOW;
            end else begin
               state_in = ST_KEY;
            end
         end
         ST_KEY: state_in = ST_CMP;
         ST_CMP: begin
            if (!key_less || j_ff <= ADDR_W'(1)) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE:    state_in = ST_OUTER;
         ST_RD_LOW:   state_in = ST_RD_MID;
         ST_RD_MID:   state_in = ST_RD_HIGH;
         ST_RD_HIGH:  state_in = ST_CAP_HIGH;
         ST_CAP_HIGH: state_in = ST_RESULT;
         ST_RESULT: begin
            if (!rsp_stall) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      count_in    = count_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      key_in      = key_ff;
      q_low_in    = q_low_ff;
      q_mid_in    = q_mid_ff;
      q_high_in   = q_high_ff;
      mem_ctrl    = '0;
      mem_wr_addr = j_ff;
      mem_wr_data = key_ff;
      mem_rd_addr = '0;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_stall   = 1'b0;
            mem_wr_addr = count_ff[ADDR_W-1:0];
            mem_wr_data = req_heat;
            i_in        = CNT_W'(1);
            if (accept && req_carries_heat && room) begin
               mem_ctrl.wr_en = 1'b1;
               count_in       = count_ff + CNT_W'(1);
            end
         end
         ST_OUTER: begin
            mem_rd_addr = i_ff[ADDR_W-1:0];
            j_in        = i_ff[ADDR_W-1:0];
            if (i_ff < count_ff) begin
               mem_ctrl.rd_en = 1'b1;
            end else begin
               q_low_in  = '0;
               q_mid_in  = '0;
               q_high_in = '0;
            end
         end
         ST_KEY: begin
            key_in         = $signed(mem_rd_data);
            mem_ctrl.rd_en = 1'b1;
            mem_rd_addr    = j_ff - ADDR_W'(1);
         end
         ST_CMP: begin
            // shift the larger neighbor up one slot, keep walking down
            if (key_less) begin
               mem_ctrl.wr_en = 1'b1;
               mem_wr_data    = mem_rd_data;
               j_in           = j_ff - ADDR_W'(1);
               if (j_ff > ADDR_W'(1)) begin
                  mem_ctrl.rd_en = 1'b1;
                  mem_rd_addr    = j_ff - ADDR_W'(2);
               end
            end
         end
         ST_PLACE: begin
            mem_ctrl.wr_en = 1'b1;
            i_in           = i_ff + CNT_W'(1);
         end
         ST_RD_LOW: begin
            mem_ctrl.rd_en = 1'b1;
            mem_rd_addr    = pos_low[ADDR_W-1:0];
         end
         ST_RD_MID: begin
            mem_ctrl.rd_en = 1'b1;
            mem_rd_addr    = pos_mid[ADDR_W-1:0];
            q_low_in       = mem_rd_data;
         end
         ST_RD_HIGH: begin
            mem_ctrl.rd_en = 1'b1;
            mem_rd_addr    = pos_high[ADDR_W-1:0];
            q_mid_in       = mem_rd_data;
         end
         ST_CAP_HIGH: begin
            q_high_in = mem_rd_data;
         end
         ST_RESULT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               count_in = '0;
            end
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      key_ff    <= key_in;
      q_low_ff  <= q_low_in;
      q_mid_ff  <= q_mid_in;
      q_high_ff <= q_high_in;
   end

   assign rsp_quartile_low  = q_low_ff;
   assign rsp_quartile_mid  = q_mid_ff;
   assign rsp_quartile_high = q_high_ff;
   assign rsp_entries_used  = COUNT_W'(count_ff);

endmodule

// ===== rtl/heat_quartile_thresholds.sv =====
// Loading: one word per cycle; req_stall is low only while the set is being loaded.
// Ranking after the last word: insertion sort through one comparator and one store
// read port for n >= 1 kept values; an empty set skips the sort and the quartile reads.
// Result stays on the rsp_ port until taken; the next set starts loading after that.
// Synchronous reset empties the set and returns to loading; the store is not cleared.
module heat_quartile_thresholds import hqt_pkg::*; #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [HEAT_W-1:0]   req_heat,
   input  logic                req_carries_heat,
   input  logic                req_is_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [HEAT_W-1:0]   rsp_quartile_low,
   output logic [HEAT_W-1:0]   rsp_quartile_mid,
   output logic [HEAT_W-1:0]   rsp_quartile_high,
   output logic [COUNT_W-1:0]  rsp_entries_used
);

   localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

   mem_ctrl_type        mem_ctrl;
   logic [ADDR_W-1:0]   mem_wr_addr;
   logic [HEAT_W-1:0]   mem_wr_data;
   logic [ADDR_W-1:0]   mem_rd_addr;
   logic [HEAT_W-1:0]   mem_rd_data;

   hqt_seq #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ADDR_W      (ADDR_W),
      .CNT_W       (CNT_W)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_heat          (req_heat),
      .req_carries_heat  (req_carries_heat),
      .req_is_last       (req_is_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_quartile_low  (rsp_quartile_low),
      .rsp_quartile_mid  (rsp_quartile_mid),
      .rsp_quartile_high (rsp_quartile_high),
      .rsp_entries_used  (rsp_entries_used),
      .mem_ctrl          (mem_ctrl),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data)
   );

   hqt_store #(
      .DEPTH  (MAX_ENTRIES),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock      (clock),
      .ctrl       (mem_ctrl),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

endmodule

// ===== rtl/hqt_checker.sv =====
// Port-level checks for the heat quartile threshold block, bound to the top level.
module hqt_checker import hqt_pkg::*; #(
   parameter int MAX_ENTRIES = 1024
) (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [HEAT_W-1:0]   rsp_quartile_low,
   input logic [HEAT_W-1:0]   rsp_quartile_mid,
   input logic [HEAT_W-1:0]   rsp_quartile_high,
   input logic [COUNT_W-1:0]  rsp_entries_used
);

   // a pending result stays valid and its mid quartile holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_quartile_mid))
      else $error("result word dropped or changed while stalled");

   // no new word is taken while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while result pending");

   // empty set gives zero quartiles
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entries_used == '0 && MAX_ENTRIES < 2048 |->
         rsp_quartile_low == '0 && rsp_quartile_mid == '0 && rsp_quartile_high == '0)
      else $error("empty set gave nonzero quartiles");

   // quartiles come from a sorted set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         $signed(rsp_quartile_low) <= $signed(rsp_quartile_mid) &&
         $signed(rsp_quartile_mid) <= $signed(rsp_quartile_high))
      else $error("quartiles out of order");

endmodule

bind heat_quartile_thresholds hqt_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_hqt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_quartile_low  (rsp_quartile_low),
   .rsp_quartile_mid  (rsp_quartile_mid),
   .rsp_quartile_high (rsp_quartile_high),
   .rsp_entries_used  (rsp_entries_used)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for heat_quartile_thresholds: sets of heat words in, quartiles out.
module testbench;
   import hqt_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int RANDOM_WORDS = 550;

   typedef logic signed [HEAT_W-1:0] heat_t;

   localparam heat_t HEAT_MIN = {1'b1, {(HEAT_W-1){1'b0}}};
   localparam heat_t HEAT_MAX = {1'b0, {(HEAT_W-1){1'b1}}};

   // value spreads for random sets
   localparam int SPREAD_WIDE   = 0;
   localparam int SPREAD_NARROW = 1;
   localparam int SPREAD_EDGE   = 2;
   localparam int SPREAD_MIXED  = 3;

   // receiver stall patterns
   localparam int STALL_NONE     = 0;
   localparam int STALL_RANDOM   = 1;
   localparam int STALL_HEAVY    = 2;
   localparam int STALL_PERIODIC = 3;

   typedef struct packed {
      logic [HEAT_W-1:0]  q_low;
      logic [HEAT_W-1:0]  q_mid;
      logic [HEAT_W-1:0]  q_high;
      logic [COUNT_W-1:0] used;
   } quartile_result_t;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [HEAT_W-1:0]   req_heat = '0;
   logic                req_carries_heat = 1'b0;
   logic                req_is_last = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [HEAT_W-1:0]   rsp_quartile_low;
   logic [HEAT_W-1:0]   rsp_quartile_mid;
   logic [HEAT_W-1:0]   rsp_quartile_high;
   logic [COUNT_W-1:0]  rsp_entries_used;

   // running copy of the set, kept in ascending order as words arrive
   heat_t            ranked_heat [STORE_DEPTH];
   int               kept_count = 0;
   quartile_result_t pending_results [$];

   int error_count = 0;
   int results_checked = 0;
   int sets_closed = 0;
   int words_kept = 0;
   int words_dropped = 0;
   int largest_set = 0;
   int random_words = 0;

   int burst_left = 0;
   bit line_busy = 1'b0;
   int stall_mode = STALL_NONE;
   int stall_left = 0;

   heat_quartile_thresholds #(.MAX_ENTRIES(STORE_DEPTH)) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_heat          (req_heat),
      .req_carries_heat  (req_carries_heat),
      .req_is_last       (req_is_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_quartile_low  (rsp_quartile_low),
      .rsp_quartile_mid  (rsp_quartile_mid),
      .rsp_quartile_high (rsp_quartile_high),
      .rsp_entries_used  (rsp_entries_used)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("Timeout: %0d results still outstanding", pending_results.size());
      $display("Test completed with failures");
      $finish;
   end

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // Update the expected set with one accepted word; a closing word yields a result.
   task automatic track_word(input heat_t heat, input logic carries, input logic last);
      quartile_result_t res;
      int pos;
      if (carries) begin
         if (kept_count < STORE_DEPTH) begin
            pos = kept_count;
            while (pos > 0 && ranked_heat[pos-1] > heat) begin
               ranked_heat[pos] = ranked_heat[pos-1];
               pos--;
            end
            ranked_heat[pos] = heat;
            kept_count++;
            words_kept++;
         end else begin
            words_dropped++;
         end
      end
      if (last) begin
         res = '0;
         if (kept_count > 0) begin
            res.q_low  = ranked_heat[(kept_count * 25) / 100];
            res.q_mid  = ranked_heat[(kept_count * 50) / 100];
            res.q_high = ranked_heat[(kept_count * 75) / 100];
         end
         res.used = COUNT_W'(kept_count);
         pending_results.push_back(res);
         if (kept_count > largest_set) largest_set = kept_count;
         kept_count = 0;
         sets_closed++;
      end
   endtask

   // Sender: bursts of back-to-back words separated by idle gaps.
   task automatic send_word(input heat_t heat, input logic carries, input logic last);
      if (burst_left == 0) begin
         if (line_busy) begin
            req_valid <= 1'b0;
            line_busy = 1'b0;
         end
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_heat         <= heat;
      req_carries_heat <= carries;
      req_is_last      <= last;
      line_busy = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_word(heat, carries, last);
   endtask

   task automatic stop_sending();
      if (line_busy) begin
         req_valid <= 1'b0;
         line_busy = 1'b0;
      end
      burst_left = 0;
   endtask

   function automatic heat_t pick_heat(input int spread);
      int sel;
      sel = (spread == SPREAD_MIXED) ? $urandom_range(SPREAD_WIDE, SPREAD_EDGE) : spread;
      case (sel)
         SPREAD_NARROW: return heat_t'(int'($urandom_range(0, 15)) - 8);
         SPREAD_EDGE: begin
            case ($urandom_range(0, 6))
               0: return HEAT_MIN;
               1: return HEAT_MAX;
               2: return heat_t'(0);
               3: return heat_t'(-1);
               4: return heat_t'(1);
               5: return HEAT_MIN + 1;
               default: return HEAT_MAX - 1;
            endcase
         end
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic test_empty_sets();
      send_word(heat_t'(0), 1'b0, 1'b1);
      // heat on a closing word without a value must be ignored
      send_word(HEAT_MAX, 1'b0, 1'b1);
      stop_sending();
   endtask

   task automatic test_single_value();
      send_word(HEAT_MIN, 1'b1, 1'b1);
      send_word(heat_t'(7), 1'b1, 1'b0);
      send_word(heat_t'(-7), 1'b1, 1'b1);
      stop_sending();
   endtask

   task automatic test_extreme_values();
      send_word(HEAT_MIN, 1'b1, 1'b0);
      send_word(HEAT_MAX, 1'b1, 1'b0);
      send_word(heat_t'(0), 1'b1, 1'b0);
      send_word(heat_t'(-1), 1'b1, 1'b0);
      send_word(heat_t'(1), 1'b1, 1'b0);
      send_word(heat_t'(64'h0000_0000_FFFF_FFFF), 1'b1, 1'b0);
      send_word(heat_t'(64'hFFFF_FFFF_0000_0000), 1'b1, 1'b1);
      stop_sending();
   endtask

   task automatic test_ties_and_idle_words();
      send_word(heat_t'(5), 1'b1, 1'b0);
      send_word(heat_t'(5), 1'b1, 1'b0);
      send_word({$urandom, $urandom}, 1'b0, 1'b0);
      send_word(heat_t'(5), 1'b1, 1'b0);
      send_word(heat_t'(-3), 1'b1, 1'b0);
      send_word(HEAT_MIN, 1'b0, 1'b0);
      send_word(heat_t'(-3), 1'b1, 1'b0);
      send_word(heat_t'(0), 1'b0, 1'b1);
      stop_sending();
   endtask

   // Fill the store, overflow it, and close with a word that must also be dropped.
   task automatic test_store_full();
      for (int i = 0; i < STORE_DEPTH + 5; i++)
         send_word(pick_heat(SPREAD_MIXED), 1'b1, 1'b0);
      send_word(pick_heat(SPREAD_WIDE), 1'b1, 1'b1);
      stop_sending();
   endtask

   task automatic test_random_sets();
      int set_size;
      int spread;
      bit close_with_value;
      while (random_words < RANDOM_WORDS) begin
         case ($urandom_range(0, 19))
            0: set_size = 0;
            1: set_size = $urandom_range(100, 250);
            default: set_size = $urandom_range(1, 40);
         endcase
         spread = $urandom_range(SPREAD_WIDE, SPREAD_MIXED);
         close_with_value = $urandom_range(0, 1);
         for (int i = 0; i < set_size; i++) begin
            if ($urandom_range(0, 9) == 0)
               send_word({$urandom, $urandom}, 1'b0, 1'b0);
            send_word(pick_heat(spread), 1'b1, 1'b0);
            random_words++;
         end
         if (close_with_value)
            send_word(pick_heat(spread), 1'b1, 1'b1);
         else
            send_word({$urandom, $urandom}, 1'b0, 1'b1);
         random_words++;
      end
      stop_sending();
   endtask

   // Receiver stall pattern: phases of no stall, coin flips, heavy stall and a fixed rhythm.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         STALL_RANDOM:   rsp_stall <= $urandom_range(0, 1);
         STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
         STALL_PERIODIC: rsp_stall <= (stall_left % 3 != 0);
         default:        rsp_stall <= 1'b0;
      endcase
   end

   task automatic check_field(input string name, input logic [HEAT_W-1:0] got,
                              input logic [HEAT_W-1:0] want);
      if (got !== want)
         report_error($sformatf("%s: got %h, expected %h", name, got, want));
   endtask

   always @(posedge clock) begin
      quartile_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_error("result word with no closed set waiting");
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            check_field("quartile_low", rsp_quartile_low, want.q_low);
            check_field("quartile_mid", rsp_quartile_mid, want.q_mid);
            check_field("quartile_high", rsp_quartile_high, want.q_high);
            check_field("entries_used", HEAT_W'(rsp_entries_used), HEAT_W'(want.used));
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_empty_sets();
      test_single_value();
      test_extreme_values();
      test_ties_and_idle_words();
      test_store_full();
      test_random_sets();

      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (pending_results.size() != 0)
         report_error($sformatf("%0d results never arrived", pending_results.size()));

      $display("Covered %0d sets: %0d values kept, %0d dropped at a full store, largest %0d",
               sets_closed, words_kept, words_dropped, largest_set);
      $display("%0d results checked, %0d mismatches", results_checked, error_count);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
